// File: rtl/core/spfb_pkg.sv
// spfb_pkg: shared types, constants and helpers for the sky polygon face bounds block
// no dependencies

package spfb_pkg;

  localparam int MAX_VERTS_DEF    = 64;
  localparam int COORD_BITS_DEF   = 18;
  localparam int ST_FRAC_BITS_DEF = 12;

  localparam int ST_BITS = 16;
  localparam logic signed [ST_BITS-1:0] ST_MAXV = 16'sh7fff;
  localparam logic signed [ST_BITS-1:0] ST_MINV = -16'sh8000;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PICK,
    ST_FETCH,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // projection codes per face: axis index (0 x,1 y,2 z) and negate
  typedef struct packed {
    logic [1:0] axis;
    logic       neg;
  } pick_t;

  typedef struct packed {
    pick_t sa;
    pick_t sb;
    pick_t sd;
  } proj_t;

  function automatic proj_t proj_of(input logic [2:0] f);
    proj_t p;
    p = '0;
    unique case (f)
      3'd0: p = '{'{2'd1, 1'b1}, '{2'd2, 1'b0}, '{2'd0, 1'b0}};
      3'd1: p = '{'{2'd1, 1'b0}, '{2'd2, 1'b0}, '{2'd0, 1'b1}};
      3'd2: p = '{'{2'd0, 1'b0}, '{2'd2, 1'b0}, '{2'd1, 1'b0}};
      3'd3: p = '{'{2'd0, 1'b1}, '{2'd2, 1'b0}, '{2'd1, 1'b1}};
      3'd4: p = '{'{2'd1, 1'b1}, '{2'd0, 1'b1}, '{2'd2, 1'b0}};
      default: p = '{'{2'd1, 1'b1}, '{2'd0, 1'b0}, '{2'd2, 1'b1}};
    endcase
    return p;
  endfunction

  // divider control between the top level and the serial divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/core/spfb_if.sv
// spfb_if: valid/ready channel interfaces for the input and result beats
// depends on spfb_pkg for field widths

interface spfb_in_if #(
  parameter int COORD_BITS = spfb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic signed [COORD_BITS-1:0] vert_x;
  logic signed [COORD_BITS-1:0] vert_y;
  logic signed [COORD_BITS-1:0] vert_z;
  logic                         last_vertex;
  logic [2:0]                   query_face;

  modport source (output valid, opcode, vert_x, vert_y, vert_z, last_vertex, query_face,
                  input ready);
  modport sink (input valid, opcode, vert_x, vert_y, vert_z, last_vertex, query_face,
                output ready);
endinterface

interface spfb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         face;
  logic signed [15:0] s_low;
  logic signed [15:0] s_high;
  logic signed [15:0] t_low;
  logic signed [15:0] t_high;
  logic               visible;
  logic               overflow;
  logic [6:0]         vertex_count;

  modport source (output valid, face, s_low, s_high, t_low, t_high, visible, overflow,
                  vertex_count, input ready);
  modport sink (input valid, face, s_low, s_high, t_low, t_high, visible, overflow,
                vertex_count, output ready);
endinterface

// File: rtl/core/spfb_ram.sv
// spfb_ram: generic single-port ram with registered read
// no dependencies

module spfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/spfb_div.sv
// spfb_div: restoring divider, one quotient bit per cycle, with q4.12 saturation
// depends on spfb_pkg

module spfb_div #(
  parameter int COORD_BITS   = spfb_pkg::COORD_BITS_DEF,
  parameter int ST_FRAC_BITS = spfb_pkg::ST_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_BITS:0]     num,
  input  logic [COORD_BITS:0]            den,
  output spfb_pkg::div_ctl_t             ctl,
  output logic signed [spfb_pkg::ST_BITS-1:0] quo
);

  localparam int NB = COORD_BITS + 1 + ST_FRAC_BITS;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]         dividend;
  logic [NB-1:0]         q;
  logic [COORD_BITS+1:0] rem;
  logic [CB-1:0]         cnt;
  logic                  neg;
  logic                  busy;
  logic                  done;
  logic [COORD_BITS+1:0] trial;
  logic [NB-1:0]         mag_num;
  logic [NB-1:0]         big;

  assign mag_num = num[COORD_BITS] ? NB'(-num) : NB'(num);
  assign trial   = {rem[COORD_BITS:0], dividend[NB-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CB'(NB - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= mag_num << ST_FRAC_BITS;
      rem      <= '0;
      q        <= '0;
      cnt      <= '0;
      neg      <= num[COORD_BITS];
    end else if (busy) begin
      // one bit of the quotient each cycle
      dividend <= dividend << 1;
      cnt      <= cnt + 1'b1;
      if (!trial[COORD_BITS+1]) begin
        rem <= trial;
        q   <= {q[NB-2:0], 1'b1};
      end else begin
        rem <= {rem[COORD_BITS:0], dividend[NB-1]};
        q   <= {q[NB-2:0], 1'b0};
      end
    end
  end

  assign big = NB'(32768);

  always_comb begin
    if (!neg) begin
      quo = (q > NB'(32767)) ? spfb_pkg::ST_MAXV : q[15:0];
    end else begin
      quo = (q > big) ? spfb_pkg::ST_MINV : 16'(-q[15:0]);
    end
  end

  assign ctl = '{start: start, busy: busy, done: done};

endmodule

// File: rtl/core/sky_polygon_face_bounds.sv
// sky_polygon_face_bounds: an accepted vertex beat is stored while room remains; a polygon end sums
// the buffer, picks the face, then per kept vertex fetches it and runs two serial divisions (s, then
// t), skips the divisions for a skipped vertex, and emits; a read result is valid the cycle after
// accept, a clear resets all face bounds. one item at a time: no beat is taken until idle, result taken.
// reset (synchronous, rst high) empties the buffer, clears all face bounds, min_depth = 1.
// depends on spfb_pkg, spfb_if, spfb_ram, spfb_div

module sky_polygon_face_bounds #(
  parameter int MAX_VERTS    = spfb_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS   = spfb_pkg::COORD_BITS_DEF,
  parameter int ST_FRAC_BITS = spfb_pkg::ST_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  spfb_in_if.sink     in_ch,
  spfb_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int FW = $clog2(MAX_VERTS + 1);
  localparam int VW = 3 * COORD_BITS;
  localparam int SW = COORD_BITS + AW + 1;

  spfb_pkg::state_t state, state_next;

  logic [7:0]                  min_depth;
  logic [FW-1:0]               fill;
  logic                        ovf_seen;
  logic [FW-1:0]               idx;
  logic signed [SW-1:0]        sum [3];
  logic [2:0]                  face_r;
  logic signed [15:0]          smin [6];
  logic signed [15:0]          smax [6];
  logic signed [15:0]          tmin [6];
  logic signed [15:0]          tmax [6];
  logic                        second;
  logic signed [15:0]          s_val;
  logic                        rd_valid;

  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [VW-1:0]               ram_wdata;
  logic [VW-1:0]               ram_rdata;
  logic signed [COORD_BITS-1:0] vc [3];

  logic                        div_start;
  logic signed [COORD_BITS:0]  div_num;
  logic [COORD_BITS:0]         div_den;
  logic signed [15:0]          div_quo;
  spfb_pkg::div_ctl_t          dctl;

  spfb_pkg::proj_t             pj;
  logic signed [COORD_BITS:0]  dval;
  logic signed [COORD_BITS:0]  aval;
  logic signed [COORD_BITS:0]  bval;
  logic                        take;
  logic                        skip;
  logic [2:0]                  qf;
  logic [2:0]                  of;

  logic signed [SW-1:0] ax, ay, az;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == spfb_pkg::ST_IDLE) && !out_ch.valid;

  assign vc[0] = ram_rdata[COORD_BITS-1:0];
  assign vc[1] = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign vc[2] = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

  assign pj = spfb_pkg::proj_of(face_r);

  function automatic logic signed [COORD_BITS:0] sel(
    input logic signed [COORD_BITS-1:0] a0, input logic signed [COORD_BITS-1:0] a1,
    input logic signed [COORD_BITS-1:0] a2, input spfb_pkg::pick_t p);
    logic signed [COORD_BITS:0] v;
    v = (p.axis == 2'd0) ? (COORD_BITS+1)'(a0) :
        (p.axis == 2'd1) ? (COORD_BITS+1)'(a1) : (COORD_BITS+1)'(a2);
    return p.neg ? -v : v;
  endfunction

  assign dval = sel(vc[0], vc[1], vc[2], pj.sd);
  assign aval = sel(vc[0], vc[1], vc[2], pj.sa);
  assign bval = sel(vc[0], vc[1], vc[2], pj.sb);
  assign skip = (dval <= 0) || (dval < $signed({1'b0, (COORD_BITS)'(min_depth)}));

  assign ax = sum[0][SW-1] ? -sum[0] : sum[0];
  assign ay = sum[1][SW-1] ? -sum[1] : sum[1];
  assign az = sum[2][SW-1] ? -sum[2] : sum[2];

  spfb_ram #(.WIDTH(VW), .DEPTH(MAX_VERTS)) u_buf (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  spfb_div #(.COORD_BITS(COORD_BITS), .ST_FRAC_BITS(ST_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .ctl(dctl), .quo(div_quo)
  );

  // the t division starts in the cycle the s quotient is done
  assign div_num = (second || dctl.done) ? bval : aval;
  assign div_den = dval;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx[AW-1:0];
    ram_wdata = {in_ch.vert_z, in_ch.vert_y, in_ch.vert_x};
    if (take && in_ch.opcode == spfb_pkg::OP_VERTEX && fill < FW'(MAX_VERTS)) begin
      ram_we   = 1'b1;
      ram_addr = fill[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spfb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      spfb_pkg::ST_IDLE: begin
        if (take && in_ch.opcode == spfb_pkg::OP_VERTEX && in_ch.last_vertex) begin
          state_next = spfb_pkg::ST_SUM;
        end
      end
      // sum walks the buffer; ram data arrives the cycle after its address
      spfb_pkg::ST_SUM: begin
        if (idx == fill) state_next = spfb_pkg::ST_PICK;
      end
      spfb_pkg::ST_PICK: state_next = (fill == '0) ? spfb_pkg::ST_EMIT : spfb_pkg::ST_FETCH;
      spfb_pkg::ST_FETCH: state_next = spfb_pkg::ST_DIV;
      spfb_pkg::ST_DIV: begin
        if (skip) begin
          state_next = spfb_pkg::ST_UPDATE;
        end else if (!dctl.busy && !dctl.done) begin
          div_start = 1'b1;
        end else if (dctl.done && second) begin
          state_next = spfb_pkg::ST_UPDATE;
        end else if (dctl.done) begin
          div_start = 1'b1;
        end
      end
      spfb_pkg::ST_UPDATE: begin
        state_next = (idx + 1'b1 == fill) ? spfb_pkg::ST_EMIT : spfb_pkg::ST_FETCH;
      end
      spfb_pkg::ST_EMIT: state_next = spfb_pkg::ST_IDLE;
      default: state_next = spfb_pkg::ST_IDLE;
    endcase
  end

  assign qf = (in_ch.query_face > 3'd5) ? 3'd5 : in_ch.query_face;
  assign of = (state == spfb_pkg::ST_EMIT) ? face_r : qf;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= 8'd1;
      fill      <= '0;
      ovf_seen  <= 1'b0;
      idx       <= '0;
      second    <= 1'b0;
      rd_valid  <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int f = 0; f < 6; f++) begin
        smin[f] <= spfb_pkg::ST_MAXV;
        tmin[f] <= spfb_pkg::ST_MAXV;
        smax[f] <= spfb_pkg::ST_MINV;
        tmax[f] <= spfb_pkg::ST_MINV;
      end
    end else begin
      if (cfg_we) min_depth <= cfg_wdata;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (take) begin
        unique case (spfb_pkg::opcode_t'(in_ch.opcode))
          spfb_pkg::OP_VERTEX: begin
            if (fill < FW'(MAX_VERTS)) fill <= fill + 1'b1;
            else ovf_seen <= 1'b1;
            idx <= '0;
            for (int k = 0; k < 3; k++) sum[k] <= '0;
          end
          spfb_pkg::OP_CLEAR: begin
            for (int f = 0; f < 6; f++) begin
              smin[f] <= spfb_pkg::ST_MAXV;
              tmin[f] <= spfb_pkg::ST_MAXV;
              smax[f] <= spfb_pkg::ST_MINV;
              tmax[f] <= spfb_pkg::ST_MINV;
            end
          end
          spfb_pkg::OP_READ: begin
            out_ch.valid        <= 1'b1;
            out_ch.overflow     <= 1'b0;
            out_ch.vertex_count <= '0;
          end
          default: ;
        endcase
      end
      rd_valid <= (state == spfb_pkg::ST_SUM) && (idx < fill);
      unique case (state)
        spfb_pkg::ST_SUM: begin
          if (idx < fill) idx <= idx + 1'b1;
          if (rd_valid) begin
            for (int k = 0; k < 3; k++) sum[k] <= sum[k] + SW'(vc[k]);
          end
        end
        spfb_pkg::ST_PICK: begin
          idx <= '0;
          if (ax > ay && ax > az) face_r <= sum[0][SW-1] ? 3'd1 : 3'd0;
          else if (ay > az && ay > ax) face_r <= sum[1][SW-1] ? 3'd3 : 3'd2;
          else face_r <= sum[2][SW-1] ? 3'd5 : 3'd4;
        end
        spfb_pkg::ST_DIV: begin
          if (dctl.done && !second) begin
            s_val  <= div_quo;
            second <= 1'b1;
          end else if (dctl.done) begin
            if (s_val < smin[face_r]) smin[face_r] <= s_val;
            if (s_val > smax[face_r]) smax[face_r] <= s_val;
            if (div_quo < tmin[face_r]) tmin[face_r] <= div_quo;
            if (div_quo > tmax[face_r]) tmax[face_r] <= div_quo;
          end
        end
        spfb_pkg::ST_UPDATE: begin
          second <= 1'b0;
          idx    <= idx + 1'b1;
        end
        spfb_pkg::ST_EMIT: begin
          out_ch.valid        <= 1'b1;
          out_ch.overflow     <= ovf_seen;
          out_ch.vertex_count <= 7'(fill);
          fill     <= '0;
          ovf_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == spfb_pkg::ST_EMIT) || (take && in_ch.opcode == spfb_pkg::OP_READ)) begin
      out_ch.face    <= of;
      out_ch.s_low   <= smin[of];
      out_ch.s_high  <= smax[of];
      out_ch.t_low   <= tmin[of];
      out_ch.t_high  <= tmax[of];
      out_ch.visible <= (smin[of] < smax[of]) && (tmin[of] < tmax[of]);
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_VERTS)) else $error("fill above buffer depth");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != spfb_pkg::ST_IDLE) |-> !take) else $error("item taken while busy");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == spfb_pkg::ST_EMIT) |=> out_ch.valid) else $error("result lost");
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == spfb_pkg::ST_EMIT) |=> (fill == '0 && !ovf_seen)) else $error("fill kept");
`endif

endmodule

// File: tb/spfb_checker.sv
// spfb_checker: watches the input, result and config ports of sky_polygon_face_bounds,
// predicts every result beat and compares it field by field
// depends on spfb_pkg and spfb_if
`timescale 1ns / 100ps

module spfb_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  spfb_in_if         in_ch,
  spfb_out_if        out_ch,
  output int         fail_count,
  output int         bounds_pending,
  output int         bounds_seen
);

  localparam int BUF_DEPTH = spfb_pkg::MAX_VERTS_DEF;
  localparam int FRAC      = spfb_pkg::ST_FRAC_BITS_DEF;

  typedef enum logic [2:0] {
    FACE_PX, FACE_NX, FACE_PY, FACE_NY, FACE_PZ, FACE_NZ
  } face_e;

  typedef struct {
    logic [2:0]         face;
    logic signed [15:0] s_low;
    logic signed [15:0] s_high;
    logic signed [15:0] t_low;
    logic signed [15:0] t_high;
    logic               visible;
    logic               overflow;
    logic [6:0]         vertex_count;
  } bounds_t;

  // per face: s source, t source, depth source (axis 1..3, sign = negate)
  localparam int S_SRC [6] = '{-2, 2, 1, -1, -2, -2};
  localparam int T_SRC [6] = '{3, 3, 3, 3, -1, 1};
  localparam int D_SRC [6] = '{1, -1, 2, -2, 3, -3};

  longint  poly_verts [BUF_DEPTH][3];
  int      poly_fill;
  bit      poly_overflow;
  int      s_min [6], s_max [6], t_min [6], t_max [6];
  int      depth_floor;
  bounds_t bounds_q [$];

  function automatic longint axis_value(longint x, longint y, longint z, int src);
    longint v;
    case (src < 0 ? -src : src)
      1:       v = x;
      2:       v = y;
      default: v = z;
    endcase
    return (src < 0) ? -v : v;
  endfunction

  function automatic int st_of(longint num, longint den);
    longint q;
    q = (num * (64'sd1 <<< FRAC)) / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic bounds_t face_bounds(int f, bit ovf, int cnt);
    bounds_t r;
    r.face         = f[2:0];
    r.s_low        = s_min[f][15:0];
    r.s_high       = s_max[f][15:0];
    r.t_low        = t_min[f][15:0];
    r.t_high       = t_max[f][15:0];
    r.visible      = (s_min[f] < s_max[f]) && (t_min[f] < t_max[f]);
    r.overflow     = ovf;
    r.vertex_count = cnt[6:0];
    return r;
  endfunction

  task automatic reset_bounds();
    for (int f = 0; f < 6; f++) begin
      s_min[f] = 32767;
      t_min[f] = 32767;
      s_max[f] = -32768;
      t_max[f] = -32768;
    end
  endtask

  function automatic int close_polygon();
    longint sx, sy, sz, ax, ay, az, d;
    int     f, s, t;
    face_e  fe;
    sx = 0; sy = 0; sz = 0;
    for (int i = 0; i < poly_fill; i++) begin
      sx += poly_verts[i][0];
      sy += poly_verts[i][1];
      sz += poly_verts[i][2];
    end
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    az = sz < 0 ? -sz : sz;
    // ties go to z
    if (ax > ay && ax > az)      fe = sx < 0 ? FACE_NX : FACE_PX;
    else if (ay > az && ay > ax) fe = sy < 0 ? FACE_NY : FACE_PY;
    else                         fe = sz < 0 ? FACE_NZ : FACE_PZ;
    f = int'(fe);
    for (int i = 0; i < poly_fill; i++) begin
      d = axis_value(poly_verts[i][0], poly_verts[i][1], poly_verts[i][2], D_SRC[f]);
      if (d <= 0 || d < depth_floor) continue;
      s = st_of(axis_value(poly_verts[i][0], poly_verts[i][1], poly_verts[i][2], S_SRC[f]), d);
      t = st_of(axis_value(poly_verts[i][0], poly_verts[i][1], poly_verts[i][2], T_SRC[f]), d);
      if (s < s_min[f]) s_min[f] = s;
      if (t < t_min[f]) t_min[f] = t;
      if (s > s_max[f]) s_max[f] = s;
      if (t > t_max[f]) t_max[f] = t;
    end
    return f;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bounds_t want;
    int      f;
    if (rst) begin
      poly_fill     = 0;
      poly_overflow = 0;
      depth_floor   = 1;
      fail_count    = 0;
      bounds_seen   = 0;
      reset_bounds();
      bounds_q.delete();
      bounds_pending = 0;
    end else begin
      if (cfg_we) depth_floor = int'(cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        case (spfb_pkg::opcode_t'(in_ch.opcode))
          spfb_pkg::OP_CLEAR: reset_bounds();
          spfb_pkg::OP_READ: bounds_q.push_back(
              face_bounds(in_ch.query_face > 5 ? 5 : int'(in_ch.query_face), 1'b0, 0));
          spfb_pkg::OP_VERTEX: begin
            if (poly_fill < BUF_DEPTH) begin
              poly_verts[poly_fill][0] = in_ch.vert_x;
              poly_verts[poly_fill][1] = in_ch.vert_y;
              poly_verts[poly_fill][2] = in_ch.vert_z;
              poly_fill++;
            end else begin
              poly_overflow = 1'b1;
            end
            if (in_ch.last_vertex) begin
              f = close_polygon();
              bounds_q.push_back(face_bounds(f, poly_overflow, poly_fill));
              poly_fill     = 0;
              poly_overflow = 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        bounds_seen++;
        if (bounds_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected, face %0d", $time, out_ch.face);
        end else begin
          want = bounds_q.pop_front();
          check_field("face", want.face, out_ch.face);
          check_field("s_low", want.s_low, out_ch.s_low);
          check_field("s_high", want.s_high, out_ch.s_high);
          check_field("t_low", want.t_low, out_ch.t_low);
          check_field("t_high", want.t_high, out_ch.t_high);
          check_field("visible", want.visible, out_ch.visible);
          check_field("overflow", want.overflow, out_ch.overflow);
          check_field("vertex_count", want.vertex_count, out_ch.vertex_count);
        end
      end
      bounds_pending = bounds_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for sky_polygon_face_bounds
// depends on spfb_pkg, spfb_if, the block itself and spfb_checker
`timescale 1ns / 100ps

module tb_top;

  localparam int ITEM_GOAL = 650;
  localparam int DIRECTED_BEATS = 170;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = 0;
  int fail_count, bounds_pending, bounds_seen;
  int beats_sent = 0;
  int burst_left = 0;
  int polys_sent = 0;
  int hold_asks = 0;
  int holds_done = 0;
  int rcv_cycle = 0;

  spfb_in_if  in_ch ();
  spfb_out_if out_ch ();

  sky_polygon_face_bounds u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  spfb_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
    .bounds_pending(bounds_pending), .bounds_seen(bounds_seen)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      rcv_cycle++;
      if (holds_done < hold_asks) begin
        out_ch.ready = 0;
        repeat (3000) @(negedge clk);
        holds_done++;
      end
      case ((rcv_cycle / 60) % 4)
        0: out_ch.ready = 1;
        1: out_ch.ready = $urandom_range(0, 1);
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = (rcv_cycle % 7 != 0);
      endcase
    end
  end

  task automatic send_beat(spfb_pkg::opcode_t op, int x, int y, int z, int last, int q);
    if (burst_left == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid       = 1;
    in_ch.opcode      = op;
    in_ch.vert_x      = x[17:0];
    in_ch.vert_y      = y[17:0];
    in_ch.vert_z      = z[17:0];
    in_ch.last_vertex = last[0];
    in_ch.query_face  = q[2:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  task automatic vtx(int x, int y, int z, bit last);
    send_beat(spfb_pkg::OP_VERTEX, x, y, z, int'(last), int'($urandom_range(0, 7)));
    if (last) polys_sent++;
  endtask

  task automatic set_min_depth(int v);
    in_ch.valid = 0;
    burst_left = 0;
    while (bounds_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = v[7:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic int rnd_coord();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  // vertex: full-range random, small, or (mode 1) leaning toward a chosen face so all faces get exercised
  task automatic rnd_vertex(int f, int mode, bit last);
    int c [3];
    int dom;
    for (int i = 0; i < 3; i++) c[i] = rnd_coord();
    case (mode)
      0: ;
      1: begin
        dom = $urandom_range(16, 131071);
        for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 2 * dom)) - dom;
        c[f / 2] = (f % 2) ? -dom : dom;
      end
      default: for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 600)) - 300;
    endcase
    vtx(c[0], c[1], c[2], last);
  endtask

  task automatic rnd_polygon();
    int n, f, mode;
    n = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
    f = $urandom_range(0, 5);
    mode = $urandom_range(0, 5);
    mode = mode < 3 ? 1 : mode - 3;
    for (int i = 0; i < n; i++) rnd_vertex(f, mode, i == n - 1);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = spfb_pkg::OP_VERTEX;
    in_ch.vert_x = 0;
    in_ch.vert_y = 0;
    in_ch.vert_z = 0;
    in_ch.last_vertex = 0;
    in_ch.query_face = 0;
    repeat (10) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // one polygon per face
    vtx(400, 10, -20, 0);   vtx(300, -5, 30, 1);
    vtx(-400, 10, 20, 0);   vtx(-300, 5, -30, 1);
    vtx(10, 500, 20, 1);
    vtx(10, -500, 20, 1);
    vtx(10, 20, 500, 1);
    vtx(10, 20, -500, 1);
    // ties: x equals y goes to z, y equals z goes to z, all zero goes to +z
    vtx(100, 100, 5, 1);
    vtx(5, -100, -100, 1);
    vtx(0, 0, 0, 1);
    // saturation both ways, extremes of the coordinates
    vtx(131071, 0, 0, 0);   vtx(131071, 0, 0, 0);
    vtx(1, -131071, 131071, 0); vtx(1, 131071, -131072, 1);
    vtx(-131072, -131072, -131072, 0); vtx(131071, 131071, 131071, 1);
    for (int q = 0; q < 8; q++) send_beat(spfb_pkg::OP_READ, 0, 0, 0, 0, q);
    send_beat(spfb_pkg::OP_NONE, rnd_coord(), rnd_coord(), rnd_coord(), 1, 7);
    send_beat(spfb_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    send_beat(spfb_pkg::OP_READ, 0, 0, 0, 0, 0);
    // buffer fills exactly, then overflows by two
    for (int i = 0; i < 64; i++) vtx(200 + i, i, -i, i == 63);
    for (int i = 0; i < 66; i++) vtx(-200 - i, i, 3 * i, i == 65);

    // depth threshold extremes: skipped depths, zero and negative depth
    set_min_depth(0);
    vtx(0, 5, 5, 0); vtx(-3, 1, 1, 0); vtx(50, 1, 1, 1);
    set_min_depth(255);
    vtx(254, 10, 10, 0); vtx(255, -10, 10, 0); vtx(256, 10, -10, 1);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_min_depth(1);
        1: set_min_depth(0);
        2: set_min_depth(255);
        default: set_min_depth(int'($urandom_range(0, 255)));
      endcase
      while (beats_sent < DIRECTED_BEATS + (phase + 1) * (ITEM_GOAL - DIRECTED_BEATS) / 5)
      begin
        case ($urandom_range(0, 19))
          0: send_beat(spfb_pkg::OP_READ, rnd_coord(), rnd_coord(), rnd_coord(),
                       int'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
          1: send_beat(spfb_pkg::OP_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(),
                       int'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
          2: send_beat(spfb_pkg::OP_NONE, rnd_coord(), rnd_coord(), rnd_coord(),
                       int'($urandom_range(0, 1)), int'($urandom_range(0, 7)));
          default: rnd_polygon();
        endcase
        if (phase == 2 && hold_asks == 0 && polys_sent % 17 == 0) hold_asks = 1;
      end
    end

    in_ch.valid = 0;
    while (bounds_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d beats (%0d polygons), checked %0d result beats over several depth floors",
             beats_sent, polys_sent, bounds_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
